// ===== rtl/mrp_pkg.sv =====
// Shared constants, types and the trial prime table for the Miller-Rabin unit.
// Used by every module in rtl; depends on nothing else.
package mrp_pkg;

    localparam int WIDTH     = 64;
    localparam int NUM_BASES = 12;
    localparam int PRIME_W   = 6;

    typedef logic [PRIME_W-1:0] prime_t;
    typedef logic [WIDTH-1:0]   word_t;

    // One bit of the candidate travelling down the residue chain.
    typedef struct packed {
        logic vld;
        logic dat;
    } link_t;

    function automatic prime_t prime_at(input logic [3:0] idx);
        prime_t p;
        unique case (idx)
            4'd0:    p = 6'd2;
            4'd1:    p = 6'd3;
            4'd2:    p = 6'd5;
            4'd3:    p = 6'd7;
            4'd4:    p = 6'd11;
            4'd5:    p = 6'd13;
            4'd6:    p = 6'd17;
            4'd7:    p = 6'd19;
            4'd8:    p = 6'd23;
            4'd9:    p = 6'd29;
            4'd10:   p = 6'd31;
            4'd11:   p = 6'd37;
            default: p = 6'd37;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/miller_rabin_prime_test_64_unit.sv =====
// Top level of the deterministic Miller-Rabin unit: residue chain, sequencer, multiplier.
// Depends on mrp_pkg, mrp_cell and mrp_modmul.
//
//  channel   ports                            direction
//  input     in_valid, in_stall, candidate    item in
//  output    out_valid, out_stall, is_prime   item out
//
// One item at a time. Trial division shifts the candidate through the cell
// chain; each modular product runs in the one shared multiplier, so a prime
// costs roughly NUM_BASES * 2 * WIDTH products.
// Reset clears all control state. A new item is taken as soon as the
// sequencer is idle, even while the previous result waits under out_stall.
module miller_rabin_prime_test_64_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] candidate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_prime
);
    import mrp_pkg::*;

    localparam int TW = $clog2(WIDTH + NUM_BASES);
    localparam int KW = 4;
    localparam int RW = $clog2(WIDTH);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_TRIAL  = 4'd1;
    localparam logic [3:0] ST_CHECK  = 4'd2;
    localparam logic [3:0] ST_DECOMP = 4'd3;
    localparam logic [3:0] ST_BASE   = 4'd4;
    localparam logic [3:0] ST_POW    = 4'd5;
    localparam logic [3:0] ST_MWAIT  = 4'd6;
    localparam logic [3:0] ST_EVAL   = 4'd7;
    localparam logic [3:0] ST_SQ     = 4'd8;
    localparam logic [3:0] ST_SQCHK  = 4'd9;
    localparam logic [3:0] ST_DONE   = 4'd10;

    localparam logic [1:0] DST_RES  = 2'd0;
    localparam logic [1:0] DST_BASE = 2'd1;
    localparam logic [1:0] DST_SQ   = 2'd2;

    logic [3:0]    state_reg, state_next;
    logic [TW-1:0] tcnt_reg, tcnt_next;
    logic [KW-1:0] k_reg, k_next;
    logic [RW-1:0] r_reg, r_next;
    logic [RW-1:0] i_reg, i_next;
    logic [1:0]    dst_reg, dst_next;
    word_t         n_reg, n_next;
    word_t         sh_reg, sh_next;
    word_t         d_reg, d_next;
    word_t         e_reg, e_next;
    word_t         res_reg, res_next;
    word_t         base_reg, base_next;
    logic          result_reg, result_next;
    logic          out_valid_reg, out_valid_next;
    logic          is_prime_reg, is_prime_next;

    logic          clear;
    link_t         links [NUM_BASES+1];
    prime_t        residues [NUM_BASES];
    logic          hit;
    logic          hit_eq;
    word_t         nm1;
    word_t         prime_k;

    logic          mm_start;
    word_t         mm_a, mm_b;
    logic          mm_busy, mm_done;
    word_t         mm_product;

    assign nm1     = n_reg - 1'b1;
    assign prime_k = {{(WIDTH-PRIME_W){1'b0}}, prime_at(k_reg)};
    assign clear   = (state_reg == ST_IDLE) && in_valid;

    assign links[0].vld = (state_reg == ST_TRIAL) && (tcnt_reg < TW'(WIDTH));
    assign links[0].dat = sh_reg[WIDTH-1];

    genvar g;
    generate
        for (g = 0; g < NUM_BASES; g++)
        begin : g_cell
            mrp_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .clear    (clear),
                .prime    (prime_at(KW'(g))),
                .link_in  (links[g]),
                .link_out (links[g+1]),
                .residue  (residues[g])
            );
        end
    endgenerate

    // The first small prime that divides the candidate decides the answer.
    always_comb
    begin
        hit    = 1'b0;
        hit_eq = 1'b0;
        for (int j = NUM_BASES - 1; j >= 0; j--)
        begin
            if (residues[j] == '0)
            begin
                hit    = 1'b1;
                hit_eq = (n_reg == {{(WIDTH-PRIME_W){1'b0}}, prime_at(KW'(j))});
            end
        end
    end

    mrp_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .a       (mm_a),
        .b       (mm_b),
        .m       (n_reg),
        .busy    (mm_busy),
        .done    (mm_done),
        .product (mm_product)
    );

    always_comb
    begin
        state_next     = state_reg;
        tcnt_next      = tcnt_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        i_next         = i_reg;
        dst_next       = dst_reg;
        n_next         = n_reg;
        sh_next        = sh_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        res_next       = res_reg;
        base_next      = base_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        is_prime_next  = is_prime_reg;
        mm_start       = 1'b0;
        mm_a           = base_reg;
        mm_b           = base_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = candidate[WIDTH-1:0];
                    sh_next    = candidate[WIDTH-1:0];
                    tcnt_next  = '0;
                    state_next = ST_TRIAL;
                end
            end
            ST_TRIAL:
            begin
                sh_next   = {sh_reg[WIDTH-2:0], 1'b0};
                tcnt_next = tcnt_reg + 1'b1;
                if (tcnt_reg == TW'(WIDTH + NUM_BASES - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (n_reg < word_t'(2))
                begin
                    result_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else if (hit)
                begin
                    result_next = hit_eq;
                    state_next  = ST_DONE;
                end
                else
                begin
                    d_next     = nm1;
                    r_next     = '0;
                    state_next = ST_DECOMP;
                end
            end
            ST_DECOMP:
            begin
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[WIDTH-1:1]};
                    r_next = r_reg + 1'b1;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (k_reg == KW'(NUM_BASES))
                begin
                    result_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (prime_k >= n_reg)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    res_next   = word_t'(1);
                    base_next  = prime_k;
                    e_next     = d_reg;
                    state_next = ST_POW;
                end
            end
            ST_POW:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_EVAL;
                end
                else if (e_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_a       = res_reg;
                    dst_next   = DST_RES;
                    state_next = ST_MWAIT;
                end
                else
                begin
                    mm_start   = 1'b1;
                    dst_next   = DST_BASE;
                    e_next     = {1'b0, e_reg[WIDTH-1:1]};
                    state_next = ST_MWAIT;
                end
            end
            ST_MWAIT:
            begin
                if (mm_done)
                begin
                    unique case (dst_reg)
                        DST_RES:
                        begin
                            res_next = mm_product;
                            mm_start = 1'b1;
                            dst_next = DST_BASE;
                            e_next   = {1'b0, e_reg[WIDTH-1:1]};
                        end
                        DST_BASE:
                        begin
                            base_next  = mm_product;
                            state_next = ST_POW;
                        end
                        DST_SQ:
                        begin
                            res_next   = mm_product;
                            state_next = ST_SQCHK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EVAL:
            begin
                if ((res_reg == word_t'(1)) || (res_reg == nm1))
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_BASE;
                end
                else
                begin
                    i_next     = RW'(1);
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (i_reg < r_reg)
                begin
                    mm_start   = 1'b1;
                    mm_a       = res_reg;
                    mm_b       = res_reg;
                    dst_next   = DST_SQ;
                    state_next = ST_MWAIT;
                end
                else
                begin
                    result_next = 1'b0;
                    state_next  = ST_DONE;
                end
            end
            ST_SQCHK:
            begin
                if (res_reg == nm1)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_BASE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tcnt_reg      <= '0;
            k_reg         <= '0;
            r_reg         <= '0;
            i_reg         <= '0;
            dst_reg       <= DST_RES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tcnt_reg      <= tcnt_next;
            k_reg         <= k_next;
            r_reg         <= r_next;
            i_reg         <= i_next;
            dst_reg       <= dst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        sh_reg       <= sh_next;
        d_reg        <= d_next;
        e_reg        <= e_next;
        res_reg      <= res_next;
        base_reg     <= base_next;
        result_reg   <= result_next;
        is_prime_reg <= is_prime_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> !mm_busy)
        else $error("multiplier started while busy");

    a_out_from_done : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_small_not_prime : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && (n_reg < word_t'(2)) |-> !result_reg)
        else $error("candidate below two reported prime");

    a_wait_has_work : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MWAIT) && !mm_done |-> mm_busy)
        else $error("waiting on an idle multiplier");

endmodule

// ===== rtl/mrp_cell.sv =====
// One residue cell: keeps the candidate modulo one small prime, one bit a cycle while its input link is valid.
// Depends on mrp_pkg.
module mrp_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           clear,
    input  mrp_pkg::prime_t prime,
    input  mrp_pkg::link_t  link_in,
    output mrp_pkg::link_t  link_out,
    output mrp_pkg::prime_t residue
);
    import mrp_pkg::*;

    link_t                link_reg;
    prime_t               residue_reg;
    prime_t               residue_next;
    logic [PRIME_W:0]     wide;

    // Residue below the prime, so twice it plus one bit needs one subtract.
    always_comb
    begin
        wide = {residue_reg, link_in.dat};
        if (wide >= {1'b0, prime})
        begin
            wide = wide - {1'b0, prime};
        end
        residue_next = wide[PRIME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg    <= '0;
            residue_reg <= '0;
        end
        else
        begin
            link_reg <= link_in;
            if (clear)
            begin
                residue_reg <= '0;
            end
            else if (link_in.vld)
            begin
                residue_reg <= residue_next;
            end
        end
    end

    assign link_out = link_reg;
    assign residue  = residue_reg;

endmodule

// ===== rtl/mrp_modmul.sv =====
// Iterative modular multiplier: a * b mod m by double-and-add, one bit of b a cycle.
// Depends on mrp_pkg.
module mrp_modmul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mrp_pkg::word_t a,
    input  mrp_pkg::word_t b,
    input  mrp_pkg::word_t m,
    output logic          busy,
    output logic          done,
    output mrp_pkg::word_t product
);
    import mrp_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    word_t         acc_reg;
    word_t         acc_next;
    word_t         a_reg;
    word_t         b_reg;
    logic [WIDTH:0] dbl;
    logic [WIDTH:0] sum;

    always_comb
    begin
        dbl = {acc_reg, 1'b0};
        if (dbl >= {1'b0, m})
        begin
            dbl = dbl - {1'b0, m};
        end
        sum = {1'b0, dbl[WIDTH-1:0]};
        if (b_reg[WIDTH-1])
        begin
            sum = sum + {1'b0, a_reg};
            if (sum >= {1'b0, m})
            begin
                sum = sum - {1'b0, m};
            end
        end
        acc_next = sum[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule
